// File: sv/sscd_pkg.sv
// ----------------------------------------------------------------------------
// sscd_pkg
// Shared types, constants and helper functions for the skid-steer command
// drive: command byte codes, speed limits and the duty to PWM level table.
// ----------------------------------------------------------------------------
package sscd_pkg;

    // speed limits in percent
    localparam logic [6:0] SPEED_MIN  = 7'd10;
    localparam logic [6:0] SPEED_MAX  = 7'd100;
    localparam logic [6:0] SPEED_STEP = 7'd10;

    // ascii command characters
    localparam logic [7:0] CH_W_LO   = 8'h77;
    localparam logic [7:0] CH_W_UP   = 8'h57;
    localparam logic [7:0] CH_F_LO   = 8'h66;
    localparam logic [7:0] CH_S_LO   = 8'h73;
    localparam logic [7:0] CH_S_UP   = 8'h53;
    localparam logic [7:0] CH_B_LO   = 8'h62;
    localparam logic [7:0] CH_A_LO   = 8'h61;
    localparam logic [7:0] CH_A_UP   = 8'h41;
    localparam logic [7:0] CH_L_LO   = 8'h6c;
    localparam logic [7:0] CH_D_LO   = 8'h64;
    localparam logic [7:0] CH_D_UP   = 8'h44;
    localparam logic [7:0] CH_R_LO   = 8'h72;
    localparam logic [7:0] CH_X_LO   = 8'h78;
    localparam logic [7:0] CH_X_UP   = 8'h58;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_H_LO   = 8'h68;
    localparam logic [7:0] CH_H_UP   = 8'h48;
    localparam logic [7:0] CH_Q_LO   = 8'h71;
    localparam logic [7:0] CH_Q_UP   = 8'h51;
    localparam logic [7:0] CH_Z_LO   = 8'h7a;
    localparam logic [7:0] CH_Z_UP   = 8'h5a;
    localparam logic [7:0] CH_E_LO   = 8'h65;
    localparam logic [7:0] CH_E_UP   = 8'h45;
    localparam logic [7:0] CH_C_LO   = 8'h63;
    localparam logic [7:0] CH_C_UP   = 8'h43;

    // decoded command class
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_FWD,
        CMD_REV,
        CMD_LEFT,
        CMD_RIGHT,
        CMD_STOP,
        CMD_HALT,
        CMD_DRV_UP,
        CMD_DRV_DN,
        CMD_TRN_UP,
        CMD_TRN_DN
    } t_cmd;

    // map a received byte onto its command class
    function automatic t_cmd decode_cmd(input logic [7:0] ch);
        t_cmd cmd;
        case (ch)
            CH_W_LO, CH_W_UP, CH_F_LO:  cmd = CMD_FWD;
            CH_S_LO, CH_S_UP, CH_B_LO:  cmd = CMD_REV;
            CH_A_LO, CH_A_UP, CH_L_LO:  cmd = CMD_LEFT;
            CH_D_LO, CH_D_UP, CH_R_LO:  cmd = CMD_RIGHT;
            CH_X_LO, CH_X_UP, CH_SPACE: cmd = CMD_STOP;
            CH_H_LO, CH_H_UP:           cmd = CMD_HALT;
            CH_Q_LO, CH_Q_UP:           cmd = CMD_DRV_UP;
            CH_Z_LO, CH_Z_UP:           cmd = CMD_DRV_DN;
            CH_E_LO, CH_E_UP:           cmd = CMD_TRN_UP;
            CH_C_LO, CH_C_UP:           cmd = CMD_TRN_DN;
            default:                    cmd = CMD_NONE;
        endcase
        return cmd;
    endfunction

    // raise a speed by one step, held at the top limit
    function automatic logic [6:0] speed_up(input logic [6:0] s);
        return (s > SPEED_MAX - SPEED_STEP) ? SPEED_MAX : s + SPEED_STEP;
    endfunction

    // lower a speed by one step, held at the bottom limit
    function automatic logic [6:0] speed_down(input logic [6:0] s);
        return (s < SPEED_MIN + SPEED_STEP) ? SPEED_MIN : s - SPEED_STEP;
    endfunction

    // duty magnitude to pwm level, mag * 255 / 100 truncated; magnitudes are
    // always zero or a whole number of speed steps
    function automatic logic [7:0] pwm_of(input logic [6:0] mag);
        logic [7:0] lvl;
        case (mag)
            7'd10:   lvl = 8'd25;
            7'd20:   lvl = 8'd51;
            7'd30:   lvl = 8'd76;
            7'd40:   lvl = 8'd102;
            7'd50:   lvl = 8'd127;
            7'd60:   lvl = 8'd153;
            7'd70:   lvl = 8'd178;
            7'd80:   lvl = 8'd204;
            7'd90:   lvl = 8'd229;
            7'd100:  lvl = 8'd255;
            default: lvl = 8'd0;
        endcase
        return lvl;
    endfunction

endpackage

// File: sv/skid_steer_command_drive_core.sv
// ----------------------------------------------------------------------------
// skid_steer_command_drive_core
// Command byte driven skid-steer motor control: held drive and turn speeds,
// per-side direction and pwm level, lamp flag.
// ----------------------------------------------------------------------------
// One command byte is taken per clock while o_stall is low, and every byte
// returns exactly one result, known command or not. A byte is registered on
// request in the input register, then decoded and applied to the held speeds
// and duties once the result register is free, and the result is registered;
// the output register lets a new byte in while a result waits to be taken.
// Speeds start at 10 percent and move in steps of 10 within 10..100; duty zero
// reads as forward.
module skid_steer_command_drive_core
    import sscd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // command request channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_command_byte,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_left_forward,
    output logic [7:0] o_left_pwm,
    output logic       o_right_forward,
    output logic [7:0] o_right_pwm,
    output logic       o_led_on,
    output logic [6:0] o_drive_speed_now,
    output logic [6:0] o_turn_speed_now,
    output logic       o_command_known
);

    // input register
    logic       r_cmd_vld;
    logic [7:0] r_cmd;

    // held state; duty kept as magnitude and reverse flag
    logic [6:0] r_drive_speed, n_drive_speed;
    logic [6:0] r_turn_speed,  n_turn_speed;
    logic [6:0] r_left_mag,    n_left_mag;
    logic       r_left_rev,    n_left_rev;
    logic [6:0] r_right_mag,   n_right_mag;
    logic       r_right_rev,   n_right_rev;
    logic       r_lamp,        n_lamp;

    // result register
    logic       r_out_vld;
    logic       r_left_fwd, r_right_fwd, r_led, r_known;
    logic [7:0] r_left_pwm, r_right_pwm;
    logic [6:0] r_drv_now, r_trn_now;

    logic       w_out_free;
    logic       w_go;
    t_cmd       w_cmd;

    // flow control
    assign w_out_free = !r_out_vld || !i_stall;
    assign w_go       = r_cmd_vld && w_out_free;
    assign o_stall    = r_cmd_vld && !w_out_free;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_vld <= 1'b0;
        end else if (!o_stall) begin
            r_cmd_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_cmd <= i_command_byte;
        end
    end

    // command decode and next state
    assign w_cmd = decode_cmd(r_cmd);

    always_comb begin
        n_drive_speed = r_drive_speed;
        n_turn_speed  = r_turn_speed;
        n_left_mag    = r_left_mag;
        n_left_rev    = r_left_rev;
        n_right_mag   = r_right_mag;
        n_right_rev   = r_right_rev;
        n_lamp        = r_lamp;
        case (w_cmd)
            CMD_FWD: begin
                n_lamp      = 1'b1;
                n_left_mag  = r_drive_speed;
                n_left_rev  = 1'b0;
                n_right_mag = r_drive_speed;
                n_right_rev = 1'b0;
            end
            CMD_REV: begin
                n_lamp      = 1'b1;
                n_left_mag  = r_drive_speed;
                n_left_rev  = 1'b1;
                n_right_mag = r_drive_speed;
                n_right_rev = 1'b1;
            end
            CMD_LEFT: begin
                n_lamp      = 1'b1;
                n_left_mag  = r_turn_speed;
                n_left_rev  = 1'b1;
                n_right_mag = r_turn_speed;
                n_right_rev = 1'b0;
            end
            CMD_RIGHT: begin
                n_lamp      = 1'b1;
                n_left_mag  = r_turn_speed;
                n_left_rev  = 1'b0;
                n_right_mag = r_turn_speed;
                n_right_rev = 1'b1;
            end
            CMD_STOP: begin
                n_lamp      = 1'b0;
                n_left_mag  = 7'd0;
                n_left_rev  = 1'b0;
                n_right_mag = 7'd0;
                n_right_rev = 1'b0;
            end
            CMD_HALT: begin
                n_lamp        = 1'b0;
                n_left_mag    = 7'd0;
                n_left_rev    = 1'b0;
                n_right_mag   = 7'd0;
                n_right_rev   = 1'b0;
                n_drive_speed = SPEED_MIN;
            end
            CMD_DRV_UP: n_drive_speed = speed_up(r_drive_speed);
            CMD_DRV_DN: n_drive_speed = speed_down(r_drive_speed);
            CMD_TRN_UP: n_turn_speed  = speed_up(r_turn_speed);
            CMD_TRN_DN: n_turn_speed  = speed_down(r_turn_speed);
            default: begin
                n_lamp = r_lamp;
            end
        endcase
    end

    // held state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_speed <= SPEED_MIN;
            r_turn_speed  <= SPEED_MIN;
            r_left_mag    <= 7'd0;
            r_left_rev    <= 1'b0;
            r_right_mag   <= 7'd0;
            r_right_rev   <= 1'b0;
            r_lamp        <= 1'b0;
        end else if (w_go) begin
            r_drive_speed <= n_drive_speed;
            r_turn_speed  <= n_turn_speed;
            r_left_mag    <= n_left_mag;
            r_left_rev    <= n_left_rev;
            r_right_mag   <= n_right_mag;
            r_right_rev   <= n_right_rev;
            r_lamp        <= n_lamp;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_go) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_left_fwd  <= !n_left_rev;
            r_left_pwm  <= pwm_of(n_left_mag);
            r_right_fwd <= !n_right_rev;
            r_right_pwm <= pwm_of(n_right_mag);
            r_led       <= n_lamp;
            r_drv_now   <= n_drive_speed;
            r_trn_now   <= n_turn_speed;
            r_known     <= (w_cmd != CMD_NONE);
        end
    end

    assign o_valid           = r_out_vld;
    assign o_left_forward    = r_left_fwd;
    assign o_left_pwm        = r_left_pwm;
    assign o_right_forward   = r_right_fwd;
    assign o_right_pwm       = r_right_pwm;
    assign o_led_on          = r_led;
    assign o_drive_speed_now = r_drv_now;
    assign o_turn_speed_now  = r_trn_now;
    assign o_command_known   = r_known;

endmodule

// File: sv/sscd_checker.sv
// ----------------------------------------------------------------------------
// sscd_checker
// Port-level checks on the skid-steer command drive results, bound to the
// top level.
// ----------------------------------------------------------------------------
module sscd_checker
    import sscd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_left_forward,
    input logic [7:0] o_left_pwm,
    input logic       o_right_forward,
    input logic [7:0] o_right_pwm,
    input logic       o_led_on,
    input logic [6:0] o_drive_speed_now,
    input logic [6:0] o_turn_speed_now,
    input logic       o_command_known
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_left_pwm) && $stable(o_right_pwm)
            && $stable(o_drive_speed_now) && $stable(o_turn_speed_now)
            && $stable(o_command_known))
        else $error("stalled result changed");

    // both speeds stay within their limits
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_drive_speed_now >= SPEED_MIN && o_drive_speed_now <= SPEED_MAX
            && o_turn_speed_now >= SPEED_MIN && o_turn_speed_now <= SPEED_MAX)
        else $error("speed out of range");

    // lamp off means both sides stopped and forward
    a_lamp_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_led_on |-> o_left_pwm == 8'd0 && o_right_pwm == 8'd0
            && o_left_forward && o_right_forward)
        else $error("motor running with lamp off");

    // lamp on means both sides driven
    a_lamp_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_led_on |-> o_left_pwm != 8'd0 && o_right_pwm != 8'd0)
        else $error("lamp on with a side stopped");

endmodule

bind skid_steer_command_drive_core sscd_checker u_sscd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_left_forward    (o_left_forward),
    .o_left_pwm        (o_left_pwm),
    .o_right_forward   (o_right_forward),
    .o_right_pwm       (o_right_pwm),
    .o_led_on          (o_led_on),
    .o_drive_speed_now (o_drive_speed_now),
    .o_turn_speed_now  (o_turn_speed_now),
    .o_command_known   (o_command_known)
);

// File: test/skid_steer_command_drive_core_tb.sv
// ----------------------------------------------------------------------------
// skid_steer_command_drive_core_tb
// Self-checking bench for the skid-steer command drive. Command bytes are
// sent through the request channel under random sender and receiver idling.
// A local model of the held speeds, duties and lamp predicts each result,
// and every result taken is compared field by field with the oldest
// prediction. A directed pass covers every command class, both speed
// limits and the unrecognised bytes, then mostly valid random traffic
// follows.
// ----------------------------------------------------------------------------
module skid_steer_command_drive_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sscd_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 10;

    // one expected result
    typedef struct packed {
        logic       left_fwd;
        logic [7:0] left_lvl;
        logic       right_fwd;
        logic [7:0] right_lvl;
        logic       lamp;
        logic [6:0] drive_spd;
        logic [6:0] turn_spd;
        logic       known;
    } t_drive_report;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_command_byte = 8'd0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_left_forward;
    logic [7:0] o_left_pwm;
    logic       o_right_forward;
    logic [7:0] o_right_pwm;
    logic       o_led_on;
    logic [6:0] o_drive_speed_now;
    logic [6:0] o_turn_speed_now;
    logic       o_command_known;

    // held drive state as the block should see it
    logic [6:0]        drive_spd = SPEED_MIN;
    logic [6:0]        turn_spd = SPEED_MIN;
    logic signed [7:0] left_duty = 8'sd0;
    logic signed [7:0] right_duty = 8'sd0;
    logic              lamp_on = 1'b0;

    t_drive_report pending_reports [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    int cycles = 0;
    int bytes_sent = 0;
    int bytes_known = 0;
    int reports_checked = 0;

    // every recognised key; the speed keys sit at the end
    logic [7:0] command_keys [0:24] = '{
        CH_W_UP, CH_W_LO, CH_F_LO, CH_S_UP, CH_S_LO, CH_B_LO,
        CH_A_UP, CH_A_LO, CH_L_LO, CH_D_UP, CH_D_LO, CH_R_LO,
        CH_X_UP, CH_X_LO, CH_SPACE, CH_H_UP, CH_H_LO,
        CH_Q_UP, CH_Q_LO, CH_Z_UP, CH_Z_LO, CH_E_UP, CH_E_LO, CH_C_UP, CH_C_LO
    };
    localparam int FIRST_SPEED_KEY = 17;
    localparam int LAST_KEY = 24;

    skid_steer_command_drive_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_command_byte    (i_command_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_left_forward    (o_left_forward),
        .o_left_pwm        (o_left_pwm),
        .o_right_forward   (o_right_forward),
        .o_right_pwm       (o_right_pwm),
        .o_led_on          (o_led_on),
        .o_drive_speed_now (o_drive_speed_now),
        .o_turn_speed_now  (o_turn_speed_now),
        .o_command_known   (o_command_known)
    );

    // clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // run time guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_reports.size());
            $display("** skid_steer_command_drive_core: FAILED **");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // signed duty to pwm level, magnitude * 255 / 100 truncated
    function automatic logic [7:0] duty_to_level(input logic signed [7:0] duty);
        int mag;
        mag = (duty < 0) ? -int'(duty) : int'(duty);
        if (mag > 100)
            mag = 100;
        return 8'((mag * 255) / 100);
    endfunction

    // apply one command byte to the held state and queue the expected result
    task automatic apply_command(input logic [7:0] ch);
        t_drive_report rep;
        logic known;
        logic signed [7:0] dv;
        logic signed [7:0] tv;
        known = 1'b1;
        dv = $signed({1'b0, drive_spd});
        tv = $signed({1'b0, turn_spd});
        case (ch)
            CH_W_LO, CH_W_UP, CH_F_LO: begin
                lamp_on = 1'b1; left_duty = dv; right_duty = dv;
            end
            CH_S_LO, CH_S_UP, CH_B_LO: begin
                lamp_on = 1'b1; left_duty = -dv; right_duty = -dv;
            end
            CH_A_LO, CH_A_UP, CH_L_LO: begin
                lamp_on = 1'b1; left_duty = -tv; right_duty = tv;
            end
            CH_D_LO, CH_D_UP, CH_R_LO: begin
                lamp_on = 1'b1; left_duty = tv; right_duty = -tv;
            end
            CH_X_LO, CH_X_UP, CH_SPACE: begin
                lamp_on = 1'b0; left_duty = 8'sd0; right_duty = 8'sd0;
            end
            CH_H_LO, CH_H_UP: begin
                lamp_on = 1'b0; left_duty = 8'sd0; right_duty = 8'sd0;
                drive_spd = SPEED_MIN;
            end
            CH_Q_LO, CH_Q_UP: begin
                drive_spd = (drive_spd >= SPEED_MAX - SPEED_STEP) ? SPEED_MAX
                                                                  : drive_spd + SPEED_STEP;
            end
            CH_Z_LO, CH_Z_UP: begin
                drive_spd = (drive_spd <= SPEED_MIN + SPEED_STEP) ? SPEED_MIN
                                                                  : drive_spd - SPEED_STEP;
            end
            CH_E_LO, CH_E_UP: begin
                turn_spd = (turn_spd >= SPEED_MAX - SPEED_STEP) ? SPEED_MAX
                                                                : turn_spd + SPEED_STEP;
            end
            CH_C_LO, CH_C_UP: begin
                turn_spd = (turn_spd <= SPEED_MIN + SPEED_STEP) ? SPEED_MIN
                                                                : turn_spd - SPEED_STEP;
            end
            default: begin
                known = 1'b0;
            end
        endcase
        rep.left_fwd  = (left_duty >= 0);
        rep.left_lvl  = duty_to_level(left_duty);
        rep.right_fwd = (right_duty >= 0);
        rep.right_lvl = duty_to_level(right_duty);
        rep.lamp      = lamp_on;
        rep.drive_spd = drive_spd;
        rep.turn_spd  = turn_spd;
        rep.known     = known;
        pending_reports.push_back(rep);
        if (known)
            bytes_known++;
    endtask

    // send one command request; entered and left at a rising edge
    task automatic send_command(input logic [7:0] ch);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command_byte <= ch;
        do
            @(posedge i_clk);
        while (o_stall);
        apply_command(ch);
        bytes_sent++;
    endtask

    task automatic check_field(input string fname, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            errors++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : result_check
        t_drive_report want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual pwm %0d/%0d",
                         $time, o_left_pwm, o_right_pwm);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                check_field("left_forward", want.left_fwd, o_left_forward);
                check_field("left_pwm", want.left_lvl, o_left_pwm);
                check_field("right_forward", want.right_fwd, o_right_forward);
                check_field("right_pwm", want.right_lvl, o_right_pwm);
                check_field("led_on", want.lamp, o_led_on);
                check_field("drive_speed_now", want.drive_spd, o_drive_speed_now);
                check_field("turn_speed_now", want.turn_spd, o_turn_speed_now);
                check_field("command_known", want.known, o_command_known);
                reports_checked++;
            end
        end
    end

    // every command class but halt and drive speed up, lowering at the bottom limit, a stop key
    task automatic test_command_classes();
        send_command(CH_Z_LO);
        send_command(CH_C_UP);
        send_command(CH_W_UP);
        send_command(CH_S_LO);
        send_command(CH_A_LO);
        send_command(CH_D_UP);
        send_command(CH_E_LO);
        send_command(CH_X_UP);
    endtask

    // drive speed to the top, past it, full pwm both ways, then halt
    task automatic test_speed_limits();
        repeat (10) send_command(CH_Q_LO);
        send_command(CH_F_LO);
        send_command(CH_B_LO);
        send_command(CH_H_UP);
        send_command(CH_SPACE);
    endtask

    // a right turn key, then bytes that look like commands but are not, and the byte extremes
    task automatic test_unknown_bytes();
        send_command(CH_R_LO);
        send_command(8'h46);
        send_command(8'h42);
        send_command(8'h4c);
        send_command(8'h52);
        send_command(8'h0a);
        send_command(8'h0d);
        send_command(8'h00);
        send_command(8'hff);
    endtask

    // mostly valid keys, with runs of speed keys to reach the limits, and noise
    task automatic test_random_traffic(input int n_items);
        int sent;
        int pick;
        int run_len;
        logic [7:0] key;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                key = command_keys[$urandom_range(FIRST_SPEED_KEY, LAST_KEY)];
                run_len = $urandom_range(3, 12);
                repeat (run_len) send_command(key);
                sent += run_len;
            end else if (pick < 80) begin
                send_command(command_keys[$urandom_range(0, LAST_KEY)]);
                sent++;
            end else begin
                send_command(8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    // test sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 12;
        recv_idle_pct = 62;
        test_command_classes();
        test_speed_limits();
        test_unknown_bytes();
        test_random_traffic(250);

        send_idle_pct = 62;
        recv_idle_pct = 12;
        test_random_traffic(250);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(250);
        i_valid <= 1'b0;

        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d command bytes, %0d of them recognised, under three idling mixes",
                 bytes_sent, bytes_known);
        $display("checked %0d results, %0d field mismatches", reports_checked, errors);
        if (errors == 0) begin
            $display("** skid_steer_command_drive_core: PASSED **");
        end else begin
            $display("** skid_steer_command_drive_core: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/sscd_pkg.sv
sv/skid_steer_command_drive_core.sv
sv/sscd_checker.sv
test/skid_steer_command_drive_core_tb.sv
